>>> rtl/assert_macros.svh
// Assertion macros used by the decoder datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define HTWD_CHK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define HTWD_CHK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/htwd_pkg.sv
// Shared types and constants of the tree-walk decoder.
package htwd_pkg;

  localparam int TREE_NODES = 512;
  localparam int TBL_AW     = $clog2(TREE_NODES);
  localparam int IDX_W      = 9;
  localparam int SYM_W      = 8;
  localparam int CNT_W      = 32;
  localparam int PAD_W      = 3;
  localparam int BYTE_W     = 8;
  localparam int BITS_W     = $clog2(BYTE_W + 1);
  localparam int CFG_IDX_W  = 2;

  localparam logic OP_DECODE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_ROOT_NODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_SYMBOLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PADDING_BITS  = 2'd2;

  typedef struct packed {
    logic             operation;
    logic [IDX_W-1:0] node_index;
    logic             node_is_leaf;
    logic [SYM_W-1:0] node_symbol;
    logic [IDX_W-1:0] left_child;
    logic [IDX_W-1:0] right_child;
    logic [BYTE_W-1:0] data_byte;
    logic             final_byte;
  } in_t;

  typedef struct packed {
    logic [SYM_W-1:0] decoded_symbol;
    logic             run_last;
    logic             stream_done;
  } out_t;

  typedef struct packed {
    logic             leaf;
    logic [SYM_W-1:0] symbol;
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
  } node_t;

  typedef struct packed {
    logic write_node;
    logic load_byte;
    logic rd_cur;
    logic rd_child;
    logic rd_root;
    logic store_pend;
    logic push_last;
    logic end_byte;
  } cmd_t;

  typedef struct packed {
    logic in_decode;
    logic stream_end;
    logic leaf;
    logic sym_last;
    logic more_bits;
    logic pend_v;
    logic out_free;
  } sts_t;

endpackage

>>> rtl/htwd_table.sv
// Node table: one write port, one registered read port, out-of-range reads as zero.
module htwd_table (
  input  logic                    clk,
  input  logic                    we,
  input  logic [htwd_pkg::IDX_W-1:0] waddr,
  input  htwd_pkg::node_t         wdata,
  input  logic                    re,
  input  logic [htwd_pkg::IDX_W-1:0] raddr,
  output htwd_pkg::node_t         rdata
);
  import htwd_pkg::*;

  node_t mem [TREE_NODES];
  node_t q_r;
  logic  oor_r;

  always_ff @(posedge clk) begin
    if (we && (32'(waddr) < 32'(TREE_NODES))) begin
      mem[TBL_AW'(waddr)] <= wdata;
    end
    if (re) begin
      q_r   <= mem[TBL_AW'(raddr)];
      oor_r <= !(32'(raddr) < 32'(TREE_NODES));
    end
  end

  assign rdata = oor_r ? '0 : q_r;

endmodule

>>> rtl/htwd_datapath.sv
// Datapath: config registers, walk state, bit shifter, pending and output registers.
`include "assert_macros.svh"

module htwd_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  htwd_pkg::in_t                in_data,
  input  logic                         cfg_valid,
  input  logic [htwd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [htwd_pkg::CNT_W-1:0]   cfg_data,
  input  logic                         out_ready,
  output logic                         out_valid,
  output htwd_pkg::out_t               out_data,
  input  htwd_pkg::cmd_t               cmd,
  output htwd_pkg::sts_t               sts
);
  import htwd_pkg::*;

  logic [IDX_W-1:0]  root_r;
  logic [PAD_W-1:0]  pad_r;
  logic [CNT_W-1:0]  remaining_r;
  logic [IDX_W-1:0]  cur_node_r;
  logic [BYTE_W-1:0] byte_r;
  logic [BITS_W-1:0] bits_r;
  logic              fin_r;
  logic              pend_v_r;
  logic [SYM_W-1:0]  pend_sym_r;
  logic              pend_done_r;
  logic              out_v_r;
  out_t              out_r;

  node_t            rdata;
  node_t            wnode;
  logic [IDX_W-1:0] child;
  logic [IDX_W-1:0] rd_addr;
  logic             rd_en;
  logic             push_mid;
  logic             push;

  assign wnode = '{leaf:   in_data.node_is_leaf,
                   symbol: in_data.node_symbol,
                   left:   in_data.left_child,
                   right:  in_data.right_child};

  assign child = byte_r[BYTE_W-1] ? rdata.right : rdata.left;
  assign rd_en = cmd.rd_cur | cmd.rd_child | cmd.rd_root;

  always_comb begin
    priority if (cmd.rd_child) begin
      rd_addr = child;
    end else if (cmd.rd_root) begin
      rd_addr = root_r;
    end else begin
      rd_addr = cur_node_r;
    end
  end

  htwd_table u_table (
    .clk   (clk),
    .we    (cmd.write_node),
    .waddr (in_data.node_index),
    .wdata (wnode),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  assign push_mid = cmd.store_pend && pend_v_r;
  assign push     = push_mid || cmd.push_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r      <= '0;
      pad_r       <= '0;
      remaining_r <= '0;
      cur_node_r  <= '0;
      bits_r      <= '0;
      pend_v_r    <= 1'b0;
      out_v_r     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_ROOT_NODE: begin
            root_r     <= cfg_data[IDX_W-1:0];
            cur_node_r <= cfg_data[IDX_W-1:0];
          end
          CFG_TOTAL_SYMBOLS: begin
            remaining_r <= cfg_data;
            cur_node_r  <= root_r;
          end
          CFG_PADDING_BITS: begin
            pad_r <= cfg_data[PAD_W-1:0];
          end
          default: ;
        endcase
      end
      if (cmd.load_byte) begin
        bits_r <= in_data.final_byte ? BITS_W'(BYTE_W) - BITS_W'(pad_r) : BITS_W'(BYTE_W);
      end
      if (cmd.rd_child) begin
        cur_node_r <= child;
        bits_r     <= bits_r - 1'b1;
      end
      if (cmd.store_pend || (cmd.end_byte && fin_r)) begin
        cur_node_r <= root_r;
      end
      if (cmd.store_pend) begin
        remaining_r <= remaining_r - 1'b1;
        pend_v_r    <= 1'b1;
      end
      if (cmd.push_last) begin
        pend_v_r <= 1'b0;
      end
      if (push) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_byte) begin
      byte_r <= in_data.data_byte;
      fin_r  <= in_data.final_byte;
    end else if (cmd.rd_child) begin
      byte_r <= {byte_r[BYTE_W-2:0], 1'b0};
    end
    if (cmd.store_pend) begin
      pend_sym_r  <= rdata.symbol;
      pend_done_r <= sts.sym_last;
    end
    if (push) begin
      out_r.decoded_symbol <= pend_sym_r;
      out_r.run_last       <= cmd.push_last;
      out_r.stream_done    <= pend_done_r;
    end
  end

  assign sts.in_decode  = (in_data.operation == OP_DECODE);
  assign sts.stream_end = (remaining_r == '0);
  assign sts.leaf       = rdata.leaf;
  assign sts.sym_last   = (remaining_r == CNT_W'(1));
  assign sts.more_bits  = (bits_r != '0);
  assign sts.pend_v     = pend_v_r;
  assign sts.out_free   = !out_v_r || out_ready;

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  `HTWD_CHK(a_push_room, (cmd.push_last || push_mid) |-> (!out_v_r || out_ready), "push into full output")
  `HTWD_CHK(a_done_last, (out_v_r && out_r.stream_done) |-> out_r.run_last, "stream_done without run_last")
  `HTWD_CHK(a_bit_avail, cmd.rd_child |-> (bits_r != '0), "walk step with no bit left")
  `HTWD_CHK_ALWAYS(a_reset_quiet, !rst_n |=> (!out_v_r && !pend_v_r), "result alive after reset")

endmodule

>>> rtl/htwd_ctrl.sv
// Controller: issues node writes and sequences table reads, leaf handling and result flush per decode request.
module htwd_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  htwd_pkg::sts_t sts,
  output htwd_pkg::cmd_t cmd
);
  import htwd_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_STEP  = 2'd1;
  localparam logic [1:0] ST_CHECK = 2'd2;
  localparam logic [1:0] ST_FLUSH = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (!sts.in_decode) begin
            cmd.write_node = 1'b1;
          end else if (!sts.stream_end) begin
            cmd.load_byte = 1'b1;
            cmd.rd_cur    = 1'b1;
            state_nxt     = ST_STEP;
          end
        end
      end
      ST_STEP: begin
        cmd.rd_child = 1'b1;
        state_nxt    = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts.leaf) begin
          if (!sts.pend_v || sts.out_free) begin
            cmd.store_pend = 1'b1;
            if (sts.sym_last || !sts.more_bits) begin
              cmd.end_byte = 1'b1;
              state_nxt    = ST_FLUSH;
            end else begin
              cmd.rd_root = 1'b1;
              state_nxt   = ST_STEP;
            end
          end
        end else if (sts.more_bits) begin
          cmd.rd_child = 1'b1;
        end else begin
          cmd.end_byte = 1'b1;
          state_nxt    = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!sts.pend_v) begin
          state_nxt = ST_IDLE;
        end else if (sts.out_free) begin
          cmd.push_last = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/huffman_tree_walk_decoder.sv
// Huffman tree-walk decoder: a load request writes one tree node; a decode request walks its byte
// MSB first at one bit per cycle while the output can take a held-back symbol, through the node table
// (each step is a dependent table read), after a read that fetches the current node, with a
// refetch of the root after each symbol found and a flush state to finish. Symbols of one byte
// are held back by one so that run_last marks the last; results leave through an output register,
// so the next request is taken while a result waits. Table entries read before being written
// return undefined data; no clearing pass is run after reset.
module huffman_tree_walk_decoder (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  htwd_pkg::in_t                  in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output htwd_pkg::out_t                 out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [htwd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [htwd_pkg::CNT_W-1:0]     cfg_data
);
  import htwd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  htwd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  htwd_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
